// File: sv/periodic_msd_tracker_macros.svh
// assertion macros for the periodic msd tracker
`ifndef PERIODIC_MSD_TRACKER_MACROS_SVH
`define PERIODIC_MSD_TRACKER_MACROS_SVH
`ifndef SYNTHESIS
`define PMT_ASSERT_SAME(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lbl failed");
`define PMT_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lbl failed");
`else
`define PMT_ASSERT_SAME(lbl, cond, prop)
`define PMT_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// File: sv/pmt_pkg.sv
// shared types and constants of the periodic msd tracker
package pmt_pkg;

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_UPDATE  = 2'd1;
    localparam logic [1:0] MODE_MEASURE = 2'd2;

    localparam logic REG_BOX_SIZE       = 1'b0;
    localparam logic REG_PARTICLE_COUNT = 1'b1;

    localparam logic [30:0] BOX_SIZE_RESET       = 31'd655360;
    localparam logic [10:0] PARTICLE_COUNT_RESET = 11'd1024;

    localparam logic [62:0] SUM_LIMIT  = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ROOT_LIMIT = 32'd3037000499;

    localparam int QUOT_W = 63;
    localparam int DIV_W  = 11;

    // memory write controls from the sequencer to each lane
    typedef struct packed {
        logic init_we;
        logic cnt_we;
    } lane_ctl_t;

    // per-lane findings toward the merge stage
    typedef struct packed {
        logic [62:0] sq;
        logic        cnt_sat;
        logic        sq_sat;
    } lane_res_t;

endpackage

// File: sv/pmt_lane.sv
// one axis lane: start and crossing memories, count update, squared displacement
module pmt_lane #(
    parameter int DEPTH = 1024,
    parameter int CW    = 16,
    parameter int AW    = 10
) (
    input  logic                clk,
    input  pmt_pkg::lane_ctl_t  ctl,
    input  logic [AW-1:0]       addr,
    input  logic signed [31:0]  wrapped,
    input  logic signed [31:0]  raw,
    input  logic [30:0]         box_size,
    output pmt_pkg::lane_res_t  res
);

    localparam logic signed [CW-1:0] CNT_HI = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CNT_LO = {1'b1, {(CW-1){1'b0}}};

    logic signed [31:0]   start_mem [DEPTH];
    logic signed [CW-1:0] cross_mem [DEPTH];

    logic signed [31:0]   start_q_reg;
    logic signed [CW-1:0] cross_q_reg;
    logic signed [CW-1:0] cnt_next;
    logic                 cnt_sat_next;
    logic signed [CW-1:0] cnt_reg;
    logic                 cnt_sat_reg;
    logic signed [31+CW:0] prod_reg;
    logic signed [32:0]   diff_reg;
    logic signed [63:0]   disp;
    logic [63:0]          mag;
    logic [31:0]          mag_reg;
    logic                 big_reg;
    logic [63:0]          sq_full;
    logic [62:0]          sq_reg;
    logic                 sq_sat_reg;

    // memories: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.init_we)
        begin
            start_mem[addr] <= wrapped;
            cross_mem[addr] <= '0;
        end
        else if (ctl.cnt_we)
        begin
            cross_mem[addr] <= cnt_next;
        end
        start_q_reg <= start_mem[addr];
        cross_q_reg <= cross_mem[addr];
    end

    // crossing count step with clamp
    always_comb
    begin
        cnt_next     = cross_q_reg;
        cnt_sat_next = 1'b0;
        if (raw[31])
        begin
            if (cross_q_reg == CNT_HI)
                cnt_sat_next = 1'b1;
            else
                cnt_next = cross_q_reg + CW'(1);
        end
        else if (raw[30:0] > box_size)
        begin
            if (cross_q_reg == CNT_LO)
                cnt_sat_next = 1'b1;
            else
                cnt_next = cross_q_reg - CW'(1);
        end
    end

    // unwrapped displacement and its magnitude
    assign disp = 64'(diff_reg) + 64'(prod_reg);
    assign mag  = disp[63] ? (64'd0 - $unsigned(disp)) : $unsigned(disp);
    assign sq_full = mag_reg * mag_reg;

    // lane pipeline: count, multiply, magnitude, square
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        cnt_sat_reg <= cnt_sat_next;
        prod_reg    <= $signed({1'b0, box_size}) * cnt_reg;
        diff_reg    <= {wrapped[31], wrapped} - {start_q_reg[31], start_q_reg};
        mag_reg     <= mag[31:0];
        big_reg     <= (mag > 64'(pmt_pkg::ROOT_LIMIT));
        sq_reg      <= big_reg ? pmt_pkg::SUM_LIMIT : sq_full[62:0];
        sq_sat_reg  <= big_reg;
    end

    assign res.sq      = sq_reg;
    assign res.cnt_sat = cnt_sat_reg;
    assign res.sq_sat  = sq_sat_reg;

endmodule

// File: sv/pmt_div.sv
// restoring divider, one quotient bit per cycle
module pmt_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [pmt_pkg::QUOT_W-1:0]   dividend,
    input  logic [pmt_pkg::DIV_W-1:0]    divisor,
    output logic                         done,
    output logic [pmt_pkg::QUOT_W-1:0]   quot
);

    localparam int QW = pmt_pkg::QUOT_W;
    localparam int DW = pmt_pkg::DIV_W;
    localparam int CNTW = $clog2(QW);

    logic            run_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [QW-1:0]   quo_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   div_reg;
    logic [DW:0]     trial;
    logic            take;
    logic            done_reg;

    // one trial subtraction
    assign trial = {rem_reg, quo_reg[QW-1]};
    assign take  = (trial >= {1'b0, div_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(QW - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= (divisor == '0) ? DW'(1) : divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[QW-2:0], take};
            rem_reg <= take ? DW'(trial - {1'b0, div_reg}) : trial[DW-1:0];
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// File: sv/periodic_msd_tracker.sv
// top level of the periodic msd tracker: sequencer, three axis lanes, merge, divider
//
// channel   dir   handshake                  payload
// request   in    start & !busy              mode, particle_index, wrapped_*, raw_*, last_particle
// result    out   done (one cycle)           mean_sq_disp, saturated
// config    in    psel & penable & pwrite    paddr, pwdata (prdata on reads)
//
// init and unused-mode requests hold busy through S_RD only, update requests through S_RD, S_CNT and S_MUL,
// measure requests through S_RD to S_ACC (lane pipeline plus merge and accumulate)
// the last measure request also holds busy in S_DIV until the bit-serial divider is done,
// and done pulses in the first idle cycle after that
// reset clears sum, flag and sequencer and presets the registers; the memories are not cleared
// the result is held, but done lasts one cycle and the receiver cannot stall it
module periodic_msd_tracker #(
    parameter int MAX_PARTICLES = 1024,
    parameter int COUNT_WIDTH   = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         mode,
    input  logic [9:0]         particle_index,
    input  logic signed [31:0] wrapped_x,
    input  logic signed [31:0] wrapped_y,
    input  logic signed [31:0] wrapped_z,
    input  logic signed [31:0] raw_x,
    input  logic signed [31:0] raw_y,
    input  logic signed [31:0] raw_z,
    input  logic               last_particle,
    output logic               done,
    output logic [62:0]        mean_sq_disp,
    output logic               saturated,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CNT, S_MUL, S_MAG, S_SQ, S_MRG, S_ACC, S_DIV
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [1:0]         mode_reg;
    logic [AW-1:0]      addr_reg;
    logic               valid_reg;
    logic               last_reg;
    logic signed [31:0] wx_reg, wy_reg, wz_reg;
    logic signed [31:0] rx_reg, ry_reg, rz_reg;

    logic [30:0]        box_size_reg;
    logic [10:0]        particle_count_reg;
    logic [62:0]        sum_reg;
    logic               sat_reg;
    logic               res_sat_reg;
    logic [64:0]        merge_reg;
    logic [62:0]        mean_reg;
    logic               saturated_reg;
    logic               done_reg;

    pmt_pkg::lane_ctl_t ctl;
    pmt_pkg::lane_res_t res_x, res_y, res_z;

    logic               accept;
    logic               cfg_we;
    logic [65:0]        total;
    logic               total_over;
    logic [62:0]        sum_next;
    logic               sat_next;
    logic               div_start;
    logic               div_done;
    logic [62:0]        div_quot;

    assign accept = start && (state_reg == S_IDLE);
    assign cfg_we = psel && penable && pwrite;
    assign busy   = (state_reg != S_IDLE);
    assign pready = 1'b1;

    // memory writes: start position on init, count on update and measure
    assign ctl.init_we = (state_reg == S_RD) && valid_reg && (mode_reg == pmt_pkg::MODE_INIT);
    assign ctl.cnt_we  = (state_reg == S_CNT) && valid_reg;

    // axis lanes
    pmt_lane #(.DEPTH(MAX_PARTICLES), .CW(COUNT_WIDTH), .AW(AW)) u_lane_x (
        .clk(clk), .ctl(ctl), .addr(addr_reg), .wrapped(wx_reg), .raw(rx_reg),
        .box_size(box_size_reg), .res(res_x)
    );
    pmt_lane #(.DEPTH(MAX_PARTICLES), .CW(COUNT_WIDTH), .AW(AW)) u_lane_y (
        .clk(clk), .ctl(ctl), .addr(addr_reg), .wrapped(wy_reg), .raw(ry_reg),
        .box_size(box_size_reg), .res(res_y)
    );
    pmt_lane #(.DEPTH(MAX_PARTICLES), .CW(COUNT_WIDTH), .AW(AW)) u_lane_z (
        .clk(clk), .ctl(ctl), .addr(addr_reg), .wrapped(wz_reg), .raw(rz_reg),
        .box_size(box_size_reg), .res(res_z)
    );

    // saturating accumulate of the merged lane squares
    assign total      = 66'(sum_reg) + 66'(merge_reg);
    assign total_over = (total > 66'(pmt_pkg::SUM_LIMIT));
    assign sum_next   = total_over ? pmt_pkg::SUM_LIMIT : total[62:0];
    assign sat_next   = sat_reg || total_over;
    assign div_start  = (state_reg == S_ACC) && last_reg;

    // mean by bit-serial division
    pmt_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_next),
        .divisor(particle_count_reg), .done(div_done), .quot(div_quot)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = S_RD;
            S_RD:
            begin
                if (mode_reg == pmt_pkg::MODE_UPDATE || mode_reg == pmt_pkg::MODE_MEASURE)
                    state_next = S_CNT;
                else
                    state_next = S_IDLE;
            end
            S_CNT:  state_next = S_MUL;
            S_MUL:  state_next = (mode_reg == pmt_pkg::MODE_MEASURE) ? S_MAG : S_IDLE;
            S_MAG:  state_next = S_SQ;
            S_SQ:   state_next = S_MRG;
            S_MRG:  state_next = S_ACC;
            S_ACC:  state_next = last_reg ? S_DIV : S_IDLE;
            S_DIV:  if (div_done) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // request capture, lane merge and saturation flag for the result; none of these is reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= mode;
            addr_reg  <= AW'(particle_index);
            valid_reg <= ({7'd0, particle_index} < 17'(MAX_PARTICLES));
            last_reg  <= last_particle;
            wx_reg    <= wrapped_x;
            wy_reg    <= wrapped_y;
            wz_reg    <= wrapped_z;
            rx_reg    <= raw_x;
            ry_reg    <= raw_y;
            rz_reg    <= raw_z;
        end
        if (state_reg == S_MRG)
        begin
            merge_reg <= valid_reg ?
                (65'(res_x.sq) + 65'(res_y.sq) + 65'(res_z.sq)) : 65'd0;
        end
        if (div_start)
            res_sat_reg <= sat_next;
    end

    // state, registers, sum and result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            box_size_reg       <= pmt_pkg::BOX_SIZE_RESET;
            particle_count_reg <= pmt_pkg::PARTICLE_COUNT_RESET;
            sum_reg            <= '0;
            sat_reg            <= 1'b0;
            done_reg           <= 1'b0;
            mean_reg           <= '0;
            saturated_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= 1'b0;
            if (cfg_we)
            begin
                unique case (paddr[2])
                    pmt_pkg::REG_BOX_SIZE:       box_size_reg       <= pwdata[30:0];
                    pmt_pkg::REG_PARTICLE_COUNT: particle_count_reg <= pwdata[10:0];
                    default: ;
                endcase
            end
            if (state_reg == S_MUL && valid_reg)
                sat_reg <= sat_reg || res_x.cnt_sat || res_y.cnt_sat || res_z.cnt_sat;
            if (state_reg == S_MRG && valid_reg)
                sat_reg <= sat_reg || res_x.sq_sat || res_y.sq_sat || res_z.sq_sat;
            if (state_reg == S_ACC)
            begin
                sum_reg <= last_reg ? '0 : sum_next;
                sat_reg <= last_reg ? 1'b0 : sat_next;
            end
            if (state_reg == S_DIV && div_done)
            begin
                done_reg      <= 1'b1;
                mean_reg      <= div_quot;
                saturated_reg <= res_sat_reg;
            end
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[2])
            pmt_pkg::REG_BOX_SIZE:       prdata = {1'b0, box_size_reg};
            pmt_pkg::REG_PARTICLE_COUNT: prdata = {21'd0, particle_count_reg};
            default:                     prdata = '0;
        endcase
    end

    assign done         = done_reg;
    assign mean_sq_disp = mean_reg;
    assign saturated    = saturated_reg;

`include "periodic_msd_tracker_macros.svh"

    `PMT_ASSERT_SAME(a_done_idle, done, !busy)
    `PMT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `PMT_ASSERT_SAME(a_div_only_wait, div_done, state_reg == S_DIV)
    `PMT_ASSERT_SAME(a_sum_bounded, state_reg == S_ACC, merge_reg[64:63] != 2'b11)

endmodule
